// ===== sv/nrtds_pkg.sv =====
// Shared types, codes and constants of the tank depth solver.
package nrtds_pkg;

    localparam int IO_W       = 32;
    localparam int RADIUS_W   = 21;
    localparam int ERR_W      = 32;
    localparam int ITER_W     = 8;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;
    localparam int STATUS_W   = 2;

    // Q16.16 constants
    localparam int PI_Q     = 205887;
    localparam int TWO_PI_Q = 411774;
    localparam int ONE_Q    = 65536;

    localparam logic [RADIUS_W-1:0] RADIUS_RST = 21'd196608;
    localparam logic [ERR_W-1:0]    ERRLIM_RST = 32'd8389;
    localparam logic [ITER_W-1:0]   ITLIM_RST  = 8'd100;
    localparam logic [ERR_W-1:0]    ERR_SAT    = '1;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_RADIUS = 2'd0,
        REG_ERRLIM = 2'd1,
        REG_ITLIM  = 2'd2
    } cfg_reg_t;

    typedef enum logic [STATUS_W-1:0] {
        STAT_CONV  = 2'd0,
        STAT_LIMIT = 2'd1,
        STAT_ZERO  = 2'd2
    } status_t;

    // Micro-operations of one Newton step
    typedef enum logic [3:0] {
        OP_XX, OP_PXX, OP_A1, OP_AX, OP_DQ, OP_CHK, OP_T3,
        OP_F, OP_FQ, OP_Q, OP_REL, OP_LOOP, OP_EMIT
    } op_t;

    typedef struct packed {
        logic load;
        logic go;
        op_t  op;
        logic zero_stop;
        logic emit;
    } cmd_t;

    typedef struct packed {
        logic done;
        logic tank;
        logic dv_zero;
        logic again;
        logic out_free;
    } sts_t;

endpackage

// ===== sv/nrtds_ifc.sv =====
// Request and result channel interfaces of the tank depth solver.
interface nrtds_req_if;
    logic               valid;
    logic               ready;
    logic               function_select;
    logic signed [31:0] target_volume;
    logic signed [31:0] initial_guess;

    modport source (output valid, function_select, target_volume, initial_guess,
                    input ready);
    modport sink   (input valid, function_select, target_volume, initial_guess,
                    output ready);
endinterface

interface nrtds_rsp_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] root;
    logic signed [31:0] residual;
    logic [31:0]        relative_error;
    logic [7:0]         iterations_used;
    logic [1:0]         status;

    modport source (output valid, root, residual, relative_error, iterations_used, status,
                    input ready);
    modport sink   (input valid, root, residual, relative_error, iterations_used, status,
                    output ready);
endinterface

// ===== sv/newton_raphson_tank_depth_solver.sv =====
// Newton-Raphson depth solver top level: one result word per request word,
// solving either the spherical tank volume equation or the test quadratic in
// signed Q16.16 with the relative change in Q8.24 percent. A request is taken
// only while no solve is in progress; a finished result may wait in the
// output register while the next request is taken. Each Newton step runs on
// a bit-serial multiplier, a restoring divider and a divide-by-three unit
// that takes a byte a cycle: a tank step costs five products, two quotients
// and one divide by three, a quadratic step two products and two quotients.
// The residual pass after the last step adds three products and one divide
// by three for the tank and two products for the quadratic.
module newton_raphson_tank_depth_solver #(
    parameter int VALUE_BITS = 32
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [nrtds_pkg::CFG_IDX_W-1:0]  cfg_idx,
    input  logic [nrtds_pkg::CFG_DATA_W-1:0] cfg_data,
    nrtds_req_if.sink                        req,
    nrtds_rsp_if.source                      rsp
);
    import nrtds_pkg::*;

    cmd_t cmd;
    sts_t sts;

    // Sequence the micro-operations
    nrtds_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req.ready),
        .cmd       (cmd),
        .sts       (sts)
    );

    // Hold iterates and do the arithmetic
    nrtds_dp #(.W(VALUE_BITS)) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_idx    (cfg_idx),
        .cfg_data   (cfg_data),
        .req_sel    (req.function_select),
        .req_volume (req.target_volume),
        .req_guess  (req.initial_guess),
        .cmd        (cmd),
        .sts        (sts),
        .rsp        (rsp)
    );

endmodule

// ===== sv/nrtds_mul.sv =====
// Bit-serial signed Q16.16 multiplier with rounding and saturation.
module nrtds_mul #(
    parameter int W = 32
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic signed [W-1:0] a,
    input  logic signed [W-1:0] b,
    output logic                done,
    output logic signed [W-1:0] p
);
    localparam int CW = $clog2(W);
    localparam logic [W-1:0] MINW = {1'b1, {(W-1){1'b0}}};
    localparam logic [W-1:0] MAXW = {1'b0, {(W-1){1'b1}}};

    logic              busy_reg;
    logic [CW-1:0]     cnt_reg;
    logic [2*W-1:0]    mcand_reg;
    logic [W-1:0]      mplier_reg;
    logic [2*W-1:0]    acc_reg;
    logic              neg_reg;
    logic [2*W-1:0]    acc_step;
    logic [W+15:0]     rsum;
    logic [W-1:0]      m;
    logic              big;

    function automatic logic [W-1:0] mag_w(input logic signed [W-1:0] v);
        return v[W-1] ? (~v + 1'b1) : v;
    endfunction

    // Add the current partial product
    assign acc_step = acc_reg + (mplier_reg[0] ? mcand_reg : '0);
    assign done     = busy_reg && (cnt_reg == CW'(W-1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
        end
        else if (done)
        begin
            busy_reg <= 1'b0;
        end
    end

    // Load operands, then shift one multiplier bit a cycle
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            cnt_reg    <= '0;
            mcand_reg  <= {{W{1'b0}}, mag_w(a)};
            mplier_reg <= mag_w(b);
            acc_reg    <= '0;
            neg_reg    <= a[W-1] ^ b[W-1];
        end
        else if (busy_reg)
        begin
            acc_reg    <= acc_step;
            mcand_reg  <= mcand_reg << 1;
            mplier_reg <= mplier_reg >> 1;
            cnt_reg    <= cnt_reg + 1'b1;
        end
    end

    // Round half up at bit 16, apply the sign, saturate
    always_comb
    begin
        big  = |acc_step[2*W-1:W+15];
        rsum = {1'b0, acc_step[W+14:0]} + (W+16)'(32768);
        m    = rsum[W+15:16];
        if (big)
        begin
            p = neg_reg ? MINW : MAXW;
        end
        else if (neg_reg)
        begin
            p = ~m + 1'b1;
        end
        else
        begin
            p = (m == MINW) ? MAXW : m;
        end
    end

endmodule

// ===== sv/nrtds_div.sv =====
// Restoring unsigned divider, one quotient bit a cycle.
module nrtds_div #(
    parameter int NW = 63,
    parameter int DW = 32
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic [NW-1:0] dividend,
    input  logic [DW-1:0] divisor,
    output logic          done,
    output logic [NW-1:0] quotient
);
    localparam int CW = $clog2(NW);

    logic          busy_reg;
    logic [CW-1:0] cnt_reg;
    logic [NW-1:0] dvd_reg;
    logic [DW-1:0] dvs_reg;
    logic [DW-1:0] rem_reg;
    logic [DW:0]   shifted;
    logic [DW:0]   diff;
    logic          ge;

    // Trial subtract of the shifted remainder
    assign shifted  = {rem_reg, dvd_reg[NW-1]};
    assign diff     = shifted - {1'b0, dvs_reg};
    assign ge       = (shifted >= {1'b0, dvs_reg});
    assign quotient = {dvd_reg[NW-2:0], ge};
    assign done     = busy_reg && (cnt_reg == CW'(NW-1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
        end
        else if (done)
        begin
            busy_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            cnt_reg <= '0;
            dvd_reg <= dividend;
            dvs_reg <= divisor;
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            rem_reg <= ge ? diff[DW-1:0] : shifted[DW-1:0];
            dvd_reg <= {dvd_reg[NW-2:0], ge};
            cnt_reg <= cnt_reg + 1'b1;
        end
    end

endmodule

// ===== sv/nrtds_dp.sv =====
// Datapath: configuration, iterate registers, shared multiplier and divider.
module nrtds_dp #(
    parameter int W = 32
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_we,
    input  logic [nrtds_pkg::CFG_IDX_W-1:0]      cfg_idx,
    input  logic [nrtds_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  logic                                 req_sel,
    input  logic signed [nrtds_pkg::IO_W-1:0]    req_volume,
    input  logic signed [nrtds_pkg::IO_W-1:0]    req_guess,
    input  nrtds_pkg::cmd_t                      cmd,
    output nrtds_pkg::sts_t                      sts,
    nrtds_rsp_if.source                          rsp
);
    import nrtds_pkg::*;

    localparam int XW   = W + 32;
    localparam int DIVN = W + 31;
    localparam logic signed [XW-1:0] VMAX  = {{(XW-W+1){1'b0}}, {(W-1){1'b1}}};
    localparam logic signed [XW-1:0] VMIN  = {{(XW-W+1){1'b1}}, {(W-1){1'b0}}};
    localparam logic signed [XW-1:0] O32MAX = {{(XW-31){1'b0}}, {31{1'b1}}};
    localparam logic signed [XW-1:0] O32MIN = {{(XW-31){1'b1}}, {31{1'b0}}};
    localparam logic [DIVN-1:0] QCAP = {{(DIVN-W){1'b0}}, 1'b1, {(W-1){1'b0}}};
    localparam int T3_STEPS = (W + 7) / 8;
    localparam int T3_W     = T3_STEPS * 8;
    localparam int T3_CW    = $clog2(T3_STEPS + 1);

    function automatic logic signed [W-1:0] sat_w(input logic signed [XW-1:0] v);
        logic signed [W-1:0] r;
        if (v > VMAX)
            r = VMAX[W-1:0];
        else if (v < VMIN)
            r = VMIN[W-1:0];
        else
            r = v[W-1:0];
        return r;
    endfunction

    function automatic logic signed [XW-1:0] ext_w(input logic signed [W-1:0] v);
        return {{32{v[W-1]}}, v};
    endfunction

    function automatic logic [W-1:0] mag_w(input logic signed [W-1:0] v);
        return v[W-1] ? (~v + 1'b1) : v;
    endfunction

    function automatic logic [IO_W-1:0] out32(input logic signed [W-1:0] v);
        logic signed [XW-1:0] e;
        logic [IO_W-1:0]      r;
        e = ext_w(v);
        if (e > O32MAX)
            r = O32MAX[IO_W-1:0];
        else if (e < O32MIN)
            r = O32MIN[IO_W-1:0];
        else
            r = e[IO_W-1:0];
        return r;
    endfunction

    // Configuration and result handshake state
    logic [RADIUS_W-1:0] radius_reg;
    logic [ERR_W-1:0]    errlim_reg;
    logic [ITER_W-1:0]   itlim_reg;
    logic                out_valid_reg;

    // Iterate and working registers
    logic                tank_reg;
    logic signed [W-1:0] x_reg, c_reg, xx_reg, pxx_reg, a1_reg, dv_reg;
    logic signed [W-1:0] tq_reg, fv_reg, nx_reg;
    logic                tneg_reg, qneg_reg, rel_keep_reg, rel_sat_reg, zero_reg;
    logic [ERR_W-1:0]    ea_reg;
    logic [ITER_W-1:0]   iter_reg;
    op_t                 pend_reg;

    logic [IO_W-1:0]     root_reg, residual_reg, relerr_reg;
    logic [ITER_W-1:0]   iters_reg;
    logic [STATUS_W-1:0] status_reg;

    // Unit connections
    logic                mul_start, mul_done, div_start, div_done;
    logic signed [W-1:0] mul_a, mul_b, mul_p;
    logic [DIVN-1:0]     div_dvd, div_q;
    logic [W-1:0]        div_dvs;

    // Divide-by-three unit
    logic                t3_start, t3_done, t3_busy_reg;
    logic [T3_CW-1:0]    t3_cnt_reg;
    logic [T3_W-1:0]     t3_sh_reg, t3_quot;
    logic [1:0]          t3_rem_reg, t3_r;
    logic [2:0]          t3_s;
    logic [7:0]          t3_qb;

    // Combinational helpers
    logic signed [W-1:0]  radius_w, t_val, dq_val, fq_val, d1_val, twox_val;
    logic signed [XW-1:0] r_x, r3_x, t_full, diff_x, absdiff_x;
    logic [W-1:0]         num, den;
    logic [W+1:0]         den3;
    logic [W+6:0]         num100;
    logic [W-1:0]         qcap_w;
    logic signed [XW-1:0] qs_x;
    logic signed [W-1:0]  qv;
    logic signed [W-1:0]  in_c, in_x;

    assign radius_w = {{(W-RADIUS_W){1'b0}}, radius_reg};
    assign in_c     = sat_w({{W{req_volume[IO_W-1]}}, req_volume});
    assign in_x     = sat_w({{W{req_guess[IO_W-1]}}, req_guess});

    // Tank height term, quadratic function and derivative
    always_comb
    begin
        r_x      = {{(XW-RADIUS_W){1'b0}}, radius_reg};
        r3_x     = r_x + (r_x <<< 1);
        t_full   = ext_w(sat_w(r3_x)) - ext_w(x_reg);
        t_val    = sat_w(t_full);
        twox_val = sat_w(ext_w(x_reg) <<< 1);
        dq_val   = sat_w(ext_w(twox_val) - XW'(5 * ONE_Q));
        d1_val   = sat_w(ext_w(xx_reg) - ext_w(pxx_reg));
        fq_val   = sat_w(ext_w(d1_val) + XW'(6 * ONE_Q));
    end

    // Relative change operands
    always_comb
    begin
        diff_x    = ext_w(nx_reg) - ext_w(x_reg);
        absdiff_x = diff_x[XW-1] ? -diff_x : diff_x;
        num       = absdiff_x[W-1:0];
        den       = mag_w(nx_reg);
        den3      = {2'b0, den} + {1'b0, den, 1'b0};
        num100    = ({7'b0, num} << 6) + ({7'b0, num} << 5) + ({7'b0, num} << 2);
    end

    // Newton step from the capped quotient
    always_comb
    begin
        qcap_w = (div_q > QCAP) ? QCAP[W-1:0] : div_q[W-1:0];
        qs_x   = {{(XW-W){1'b0}}, qcap_w};
        if (qneg_reg)
        begin
            qs_x = -qs_x;
        end
        qv = sat_w(qs_x);
    end

    // Divide by three a byte a cycle, carrying the remainder between bytes
    always_comb
    begin
        t3_r  = t3_rem_reg;
        t3_s  = '0;
        t3_qb = '0;
        for (int i = 7; i >= 0; i--)
        begin
            t3_s     = {t3_r, t3_sh_reg[T3_W-8+i]};
            t3_qb[i] = (t3_s >= 3'd3);
            t3_r     = t3_qb[i] ? 2'(t3_s - 3'd3) : t3_s[1:0];
        end
        t3_quot = {t3_sh_reg[T3_W-9:0], t3_qb};
    end

    assign t3_done = t3_busy_reg && (t3_cnt_reg == T3_CW'(T3_STEPS - 1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            t3_busy_reg <= 1'b0;
        end
        else if (t3_start)
        begin
            t3_busy_reg <= 1'b1;
        end
        else if (t3_done)
        begin
            t3_busy_reg <= 1'b0;
        end
    end

    // Load the height magnitude, then advance one byte a cycle
    always_ff @(posedge clk)
    begin
        if (t3_start)
        begin
            t3_cnt_reg <= '0;
            t3_sh_reg  <= T3_W'(mag_w(t_val));
            t3_rem_reg <= '0;
        end
        else if (t3_busy_reg)
        begin
            t3_cnt_reg <= t3_cnt_reg + 1'b1;
            t3_sh_reg  <= t3_quot;
            t3_rem_reg <= t3_r;
        end
    end

    // Select operands for the shared units
    always_comb
    begin
        mul_start = 1'b0;
        div_start = 1'b0;
        t3_start  = 1'b0;
        mul_a     = x_reg;
        mul_b     = x_reg;
        div_dvd   = {num100, 24'b0};
        div_dvs   = den;
        if (cmd.go)
        begin
            case (cmd.op) inside
                OP_XX, OP_PXX, OP_A1, OP_AX, OP_F: mul_start = 1'b1;
                OP_Q, OP_REL:                      div_start = 1'b1;
                OP_T3:                             t3_start  = 1'b1;
                default:                           ;
            endcase
        end
        case (cmd.op)
            OP_PXX:
            begin
                mul_a = tank_reg ? W'(PI_Q) : x_reg;
                mul_b = tank_reg ? xx_reg : W'(5 * ONE_Q);
            end
            OP_A1:
            begin
                mul_a = W'(TWO_PI_Q);
                mul_b = radius_w;
            end
            OP_AX:
            begin
                mul_a = a1_reg;
                mul_b = x_reg;
            end
            OP_F:
            begin
                mul_a = pxx_reg;
                mul_b = tq_reg;
            end
            OP_Q:
            begin
                div_dvd = {{(DIVN-W-16){1'b0}}, mag_w(fv_reg), 16'b0};
                div_dvs = mag_w(dv_reg);
            end
            default: ;
        endcase
    end

    nrtds_mul #(.W(W)) u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mul_start),
        .a     (mul_a),
        .b     (mul_b),
        .done  (mul_done),
        .p     (mul_p)
    );

    nrtds_div #(.NW(DIVN), .DW(W)) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dvd),
        .divisor  (div_dvs),
        .done     (div_done),
        .quotient (div_q)
    );

    // Configuration writes and result valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radius_reg    <= RADIUS_RST;
            errlim_reg    <= ERRLIM_RST;
            itlim_reg     <= ITLIM_RST;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_idx)
                    REG_RADIUS: radius_reg <= cfg_data[RADIUS_W-1:0];
                    REG_ERRLIM: errlim_reg <= cfg_data[ERR_W-1:0];
                    REG_ITLIM:  itlim_reg  <= cfg_data[ITER_W-1:0];
                    default:    ;
                endcase
            end
            if (cmd.emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Load, write back and emit
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            tank_reg <= ~req_sel;
            c_reg    <= in_c;
            x_reg    <= in_x;
            iter_reg <= '0;
            zero_reg <= 1'b0;
            ea_reg   <= (errlim_reg == ERR_SAT) ? ERR_SAT : errlim_reg + 1'b1;
        end
        if (cmd.zero_stop)
        begin
            zero_reg <= 1'b1;
        end
        if (cmd.go)
        begin
            pend_reg <= cmd.op;
            case (cmd.op)
                OP_DQ:  dv_reg <= dq_val;
                OP_FQ:  fv_reg <= fq_val;
                OP_T3:  tneg_reg <= t_val[W-1];
                OP_Q:   qneg_reg <= fv_reg[W-1] ^ dv_reg[W-1];
                OP_REL:
                begin
                    rel_keep_reg <= (nx_reg == '0);
                    rel_sat_reg  <= ({2'b0, num} >= den3);
                end
                default: ;
            endcase
        end
        if (mul_done)
        begin
            case (pend_reg)
                OP_XX:   xx_reg  <= mul_p;
                OP_PXX:  pxx_reg <= mul_p;
                OP_A1:   a1_reg  <= mul_p;
                OP_AX:   dv_reg  <= sat_w(ext_w(mul_p) - ext_w(pxx_reg));
                OP_F:    fv_reg  <= sat_w(ext_w(mul_p) - ext_w(c_reg));
                default: ;
            endcase
        end
        if (t3_done)
        begin
            tq_reg <= tneg_reg ? (~t3_quot[W-1:0] + 1'b1) : t3_quot[W-1:0];
        end
        if (div_done)
        begin
            case (pend_reg)
                OP_Q:
                begin
                    nx_reg   <= sat_w(ext_w(x_reg) - ext_w(qv));
                    iter_reg <= iter_reg + 1'b1;
                end
                OP_REL:
                begin
                    x_reg <= nx_reg;
                    if (!rel_keep_reg)
                    begin
                        if (rel_sat_reg || (|div_q[DIVN-1:ERR_W]))
                            ea_reg <= ERR_SAT;
                        else
                            ea_reg <= div_q[ERR_W-1:0];
                    end
                end
                default: ;
            endcase
        end
        if (cmd.emit)
        begin
            root_reg     <= out32(x_reg);
            residual_reg <= out32(fv_reg);
            relerr_reg   <= ea_reg;
            iters_reg    <= iter_reg;
            if (ea_reg < errlim_reg)
                status_reg <= STAT_CONV;
            else if (zero_reg)
                status_reg <= STAT_ZERO;
            else
                status_reg <= STAT_LIMIT;
        end
    end

    // Status back to the controller
    assign sts.done     = mul_done | div_done | t3_done;
    assign sts.tank     = tank_reg;
    assign sts.dv_zero  = (dv_reg == '0);
    assign sts.again    = (ea_reg >= errlim_reg) && (iter_reg < itlim_reg);
    assign sts.out_free = !out_valid_reg || rsp.ready;

    // Drive the result word
    assign rsp.valid           = out_valid_reg;
    assign rsp.root            = root_reg;
    assign rsp.residual        = residual_reg;
    assign rsp.relative_error  = relerr_reg;
    assign rsp.iterations_used = iters_reg;
    assign rsp.status          = status_reg;

endmodule

// ===== sv/nrtds_ctrl.sv =====
// Sequencer that steps the datapath through each Newton iteration.
module nrtds_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            req_valid,
    output logic            req_ready,
    output nrtds_pkg::cmd_t cmd,
    input  nrtds_pkg::sts_t sts
);
    import nrtds_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_RUN  = 3'b010,
        ST_WAIT = 3'b100
    } state_t;

    state_t state_reg, state_next;
    op_t    op_reg, op_next, follow;
    logic   fin_reg, fin_next;

    // Successor of each micro-operation
    always_comb
    begin
        case (op_reg)
            OP_XX:   follow = OP_PXX;
            OP_PXX:
            begin
                if (fin_reg)
                    follow = sts.tank ? OP_T3 : OP_FQ;
                else
                    follow = sts.tank ? OP_A1 : OP_DQ;
            end
            OP_A1:   follow = OP_AX;
            OP_AX:   follow = OP_CHK;
            OP_DQ:   follow = OP_CHK;
            OP_T3:   follow = OP_F;
            OP_F:    follow = fin_reg ? OP_EMIT : OP_Q;
            OP_FQ:   follow = fin_reg ? OP_EMIT : OP_Q;
            OP_Q:    follow = OP_REL;
            OP_REL:  follow = OP_LOOP;
            default: follow = OP_XX;
        endcase
    end

    // Issue, wait and decide
    always_comb
    begin
        state_next = state_reg;
        op_next    = op_reg;
        fin_next   = fin_reg;
        cmd        = '0;
        cmd.op     = op_reg;
        req_ready  = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    cmd.load   = 1'b1;
                    op_next    = OP_XX;
                    fin_next   = 1'b0;
                    state_next = ST_RUN;
                end
            end
            ST_RUN:
            begin
                case (op_reg)
                    OP_CHK:
                    begin
                        if (sts.dv_zero)
                        begin
                            cmd.zero_stop = 1'b1;
                            fin_next      = 1'b1;
                            op_next       = OP_XX;
                        end
                        else
                        begin
                            op_next = sts.tank ? OP_T3 : OP_FQ;
                        end
                    end
                    OP_LOOP:
                    begin
                        fin_next = !sts.again;
                        op_next  = OP_XX;
                    end
                    OP_EMIT:
                    begin
                        if (sts.out_free)
                        begin
                            cmd.emit   = 1'b1;
                            state_next = ST_IDLE;
                        end
                    end
                    OP_DQ, OP_FQ:
                    begin
                        cmd.go  = 1'b1;
                        op_next = follow;
                    end
                    default:
                    begin
                        cmd.go     = 1'b1;
                        state_next = ST_WAIT;
                    end
                endcase
            end
            ST_WAIT:
            begin
                if (sts.done)
                begin
                    op_next    = follow;
                    state_next = ST_RUN;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            op_reg    <= OP_XX;
            fin_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            op_reg    <= op_next;
            fin_reg   <= fin_next;
        end
    end

endmodule

// ===== sv/nrtds_chk.sv =====
// Port-level checks of the tank depth solver and their binding.
module nrtds_chk (
    input logic       clk,
    input logic       rst_n,
    input logic       req_valid,
    input logic       req_ready,
    input logic       rsp_valid,
    input logic       rsp_ready,
    input logic [1:0] rsp_status,
    input logic [7:0] rsp_iterations_used
);
    import nrtds_pkg::*;

    // A stalled result word stays offered
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && !rsp_ready) |=> rsp_valid)
        else $error("result word dropped while stalled");

    // A solve in progress takes no further request
    a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && req_ready) |=> !req_ready)
        else $error("request taken while a solve is running");

    // No result appears in the cycle after a request is taken
    a_no_instant_result: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && req_ready) |=> !$rose(rsp_valid))
        else $error("result appeared without any iteration");

    // Only a zero derivative ends a solve before the first step
    a_step_made: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && rsp_status != STAT_ZERO) |-> (rsp_iterations_used != 8'd0))
        else $error("solve finished without a Newton step");

endmodule

bind newton_raphson_tank_depth_solver nrtds_chk u_nrtds_chk (
    .clk                 (clk),
    .rst_n               (rst_n),
    .req_valid           (req.valid),
    .req_ready           (req.ready),
    .rsp_valid           (rsp.valid),
    .rsp_ready           (rsp.ready),
    .rsp_status          (rsp.status),
    .rsp_iterations_used (rsp.iterations_used)
);

// ===== tb/tb_newton_raphson_tank_depth_solver.sv =====
// Self-checking testbench of the Newton-Raphson tank depth solver.
module tb_newton_raphson_tank_depth_solver;
    import nrtds_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int  VB         = 32;
    localparam int  CYCLE_CAP  = 20000000;
    localparam int  LONG_HOLD  = 5000;
    localparam int  HOLD_AT    = 100;
    localparam int  PHASES     = 10;
    localparam int  PER_PHASE  = 54;

    typedef struct {
        logic signed [31:0] root;
        logic signed [31:0] residual;
        logic [31:0]        relative_error;
        logic [7:0]         iterations_used;
        status_t            status;
    } solve_res_t;

    // Solver arithmetic and the queue of awaited solutions
    class solve_board;
        logic [RADIUS_W-1:0] radius;
        logic [ERR_W-1:0]    err_lim;
        logic [ITER_W-1:0]   it_lim;
        solve_res_t          awaited[$];
        int                  faults;

        function new();
            radius  = RADIUS_RST;
            err_lim = ERRLIM_RST;
            it_lim  = ITLIM_RST;
            faults  = 0;
        endfunction

        function longint vmax();
            return (longint'(1) <<< (VB - 1)) - 1;
        endfunction

        function longint sat(longint v);
            if (v > vmax())
                return vmax();
            if (v < -vmax() - 1)
                return -vmax() - 1;
            return v;
        endfunction

        function longint unsigned absv(longint v);
            return v < 0 ? -v : v;
        endfunction

        // Round the magnitude half up at bit 16, then sign and saturate
        function longint fx_mul(longint a, longint b);
            longint unsigned ua, ub, lim, m;
            bit neg;
            ua = absv(a);
            ub = absv(b);
            neg = (a < 0) != (b < 0);
            lim = longint'(1) << (VB + 15);
            if (ub != 0 && ua > (lim - 1) / ub)
                return neg ? -vmax() - 1 : vmax();
            m = (ua * ub + 64'h8000) >> 16;
            return sat(neg ? -longint'(m) : longint'(m));
        endfunction

        // Truncate the magnitude of the quotient
        function longint fx_div(longint a, longint b);
            longint unsigned ua, ub, q, cap;
            ua = absv(a);
            ub = absv(b);
            cap = vmax() + 1;
            q = (ua << 16) / ub;
            if (q > cap)
                q = cap;
            return sat(((a < 0) != (b < 0)) ? -longint'(q) : longint'(q));
        endfunction

        function longint f_of(bit tank, longint x, longint c);
            longint t;
            if (tank)
            begin
                t = sat(sat(3 * longint'(radius)) - x) / 3;
                return sat(fx_mul(fx_mul(PI_Q, fx_mul(x, x)), t) - c);
            end
            return sat(sat(fx_mul(x, x) - fx_mul(x, 5 * ONE_Q)) + 6 * ONE_Q);
        endfunction

        function longint slope_of(bit tank, longint x);
            longint a;
            if (tank)
            begin
                a = fx_mul(fx_mul(TWO_PI_Q, longint'(radius)), x);
                return sat(a - fx_mul(PI_Q, fx_mul(x, x)));
            end
            return sat(sat(2 * x) - 5 * ONE_Q);
        endfunction

        // |num/den| * 100 in Q8.24 percent
        function longint unsigned change_pct(longint unsigned num, longint unsigned den);
            longint unsigned r, res;
            if (num >= 3 * den)
                return 64'hFFFF_FFFF;
            r = (num * 100) % den;
            res = (num * 100) / den;
            for (int i = 0; i < 24; i++)
            begin
                r = r << 1;
                res = res << 1;
                if (r >= den)
                begin
                    r = r - den;
                    res = res | 1;
                end
            end
            return res > 64'hFFFF_FFFF ? 64'hFFFF_FFFF : res;
        endfunction

        function longint clip32(longint v);
            if (v > 64'sh7FFF_FFFF)
                return 64'sh7FFF_FFFF;
            if (v < -64'sh8000_0000)
                return -64'sh8000_0000;
            return v;
        endfunction

        function void set_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] val);
            case (idx)
                REG_RADIUS: radius = val[RADIUS_W-1:0];
                REG_ERRLIM: err_lim = val;
                REG_ITLIM:  it_lim = val[ITER_W-1:0];
                default: ;
            endcase
        endfunction

        // Run the whole solve for one accepted request word
        function void note_request(logic fsel, logic signed [31:0] tv,
                                   logic signed [31:0] ig);
            bit tank;
            longint c, x, d, nx;
            longint unsigned ea, iter;
            status_t st;
            solve_res_t r;
            tank = (fsel == 1'b0);
            c = sat(longint'(tv));
            x = sat(longint'(ig));
            ea = longint'(err_lim) + 1;
            if (ea > 64'hFFFF_FFFF)
                ea = 64'hFFFF_FFFF;
            iter = 0;
            st = STAT_LIMIT;
            do
            begin
                d = slope_of(tank, x);
                if (d == 0)
                begin
                    st = STAT_ZERO;
                    break;
                end
                nx = sat(x - fx_div(f_of(tank, x, c), d));
                iter++;
                if (nx != 0)
                    ea = change_pct(absv(nx - x), absv(nx));
                x = nx;
            end
            while (ea >= err_lim && iter < it_lim);
            if (ea < err_lim)
                st = STAT_CONV;
            r.root            = clip32(x);
            r.residual        = clip32(f_of(tank, x, c));
            r.relative_error  = ea[31:0];
            r.iterations_used = iter[7:0];
            r.status          = st;
            awaited.push_back(r);
        endfunction

        function void check_result(logic signed [31:0] root, logic signed [31:0] residual,
                                   logic [31:0] rel, logic [7:0] iters, logic [1:0] stat);
            solve_res_t e;
            if (awaited.size() == 0)
            begin
                $error("result word with nothing awaited");
                faults++;
                return;
            end
            e = awaited.pop_front();
            if (root !== e.root)
            begin
                $error("root: expected %0d, got %0d", e.root, root);
                faults++;
            end
            if (residual !== e.residual)
            begin
                $error("residual: expected %0d, got %0d", e.residual, residual);
                faults++;
            end
            if (rel !== e.relative_error)
            begin
                $error("relative_error: expected %0d, got %0d", e.relative_error, rel);
                faults++;
            end
            if (iters !== e.iterations_used)
            begin
                $error("iterations_used: expected %0d, got %0d", e.iterations_used, iters);
                faults++;
            end
            if (stat !== e.status)
            begin
                $error("status: expected %0d, got %0d", e.status, stat);
                faults++;
            end
        endfunction
    endclass

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    cfg_reg_t              cfg_idx;
    logic [CFG_DATA_W-1:0] cfg_data;
    bit                    calm;
    int                    cycles;
    int                    results_seen;
    int                    hold_left;
    solve_board            sb;

    nrtds_req_if req ();
    nrtds_rsp_if rsp ();

    newton_raphson_tank_depth_solver uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_idx  (cfg_idx),
        .cfg_data (cfg_data),
        .req      (req.sink),
        .rsp      (rsp.source)
    );

    always #10 clk = ~clk;

    // Count cycles and stop a hung run
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_CAP)
        begin
            $display("newton_raphson_tank_depth_solver: mismatch");
            $finish;
        end
    end

    // Note accepted requests
    always @(posedge clk)
        if (rst_n && req.valid && req.ready)
            sb.note_request(req.function_select, req.target_volume, req.initial_guess);

    // Check accepted results
    always @(posedge clk)
        if (rst_n && rsp.valid && rsp.ready)
        begin
            sb.check_result(rsp.root, rsp.residual, rsp.relative_error,
                            rsp.iterations_used, rsp.status);
            results_seen++;
        end

    // Drive ready: random stalls, plus one long hold-off to back the block up
    always @(posedge clk)
    begin
        if (results_seen == HOLD_AT && hold_left == 0)
            hold_left = -LONG_HOLD;
        if (hold_left < 0)
        begin
            hold_left++;
            rsp.ready <= 1'b0;
            if (hold_left == 0)
                hold_left = 1;
        end
        else
            rsp.ready <= calm ? 1'b1 : ($urandom_range(99) >= 16);
    end

    task automatic write_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] val);
        @(posedge clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= val;
        sb.set_reg(idx, val);
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    // Offer one request word and hold it until taken
    task automatic send_request(logic fsel, logic signed [31:0] tv, logic signed [31:0] ig);
        while (!calm && $urandom_range(99) < 16)
        begin
            req.valid <= 1'b0;
            @(posedge clk);
        end
        req.valid           <= 1'b1;
        req.function_select <= fsel;
        req.target_volume   <= tv;
        req.initial_guess   <= ig;
        @(posedge clk);
        while (!req.ready)
            @(posedge clk);
    endtask

    // Drop valid and wait until every solution is back
    task automatic drain();
        @(posedge clk);
        req.valid <= 1'b0;
        while (sb.awaited.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    // Mostly solvable requests, some raw noise
    task automatic send_random();
        logic signed [31:0] tv, ig;
        logic               fsel;
        int unsigned        r;
        fsel = $urandom_range(1);
        r = $urandom_range(99);
        if (r < 35)
        begin
            tv = $urandom;
            ig = $urandom;
        end
        else if (fsel)
        begin
            tv = $urandom;
            ig = $urandom_range(6 * ONE_Q) - ONE_Q;
        end
        else
        begin
            tv = $urandom_range(4 * ONE_Q * 30);
            ig = $urandom_range(2 * int'(sb.radius) + 1);
        end
        send_request(fsel, tv, ig);
    endtask

    initial
    begin
        logic [31:0] ev;
        clk       = 1'b0;
        rst_n     = 1'b0;
        cfg_we    = 1'b0;
        cfg_idx   = REG_RADIUS;
        cfg_data  = '0;
        req.valid = 1'b0;
        req.function_select = 1'b0;
        req.target_volume   = '0;
        req.initial_guess   = '0;
        rsp.ready = 1'b0;
        calm      = 1'b0;
        cycles    = 0;
        results_seen = 0;
        hold_left = 0;
        sb = new();
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: reset settings, both equations, extremes and flat slopes
        send_request(1'b1, 32'sd0, 32'sd0);
        send_request(1'b1, 32'sd0, 32'sd163840);          // slope zero at 2.5
        send_request(1'b1, 32'h7FFF_FFFF, 32'sd262144);
        send_request(1'b0, 32'sd0, 32'sd0);               // tank slope zero at 0
        send_request(1'b0, 32'sd655360, 32'sd65536);
        send_request(1'b0, 32'h8000_0000, 32'sd393216);
        drain();
        write_reg(REG_ITLIM, 8'd0);
        send_request(1'b1, 32'sd0, 32'h7FFF_FFFF);
        send_request(1'b1, 32'sd0, 32'h8000_0000);
        send_request(1'b0, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        send_request(1'b0, 32'h8000_0000, 32'h8000_0000);
        send_request(1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        drain();
        write_reg(REG_ERRLIM, 32'd0);
        write_reg(REG_ITLIM, 8'd255);
        send_request(1'b1, 32'sd0, 32'sd229376);
        drain();
        write_reg(REG_ERRLIM, 32'hFFFF_FFFF);
        write_reg(REG_RADIUS, 21'd1048576);
        send_request(1'b0, 32'sd1000000, 32'sd65536);
        send_request(1'b1, 32'sd0, 32'sd65536);
        drain();
        write_reg(REG_RADIUS, 21'd0);
        write_reg(REG_ERRLIM, ERRLIM_RST);
        write_reg(REG_ITLIM, 8'd4);
        send_request(1'b0, 32'sd65536, 32'sd65536);
        send_request(1'b0, 32'sd0, 32'sd0);
        drain();

        // Random phases, each under its own settings
        for (int p = 0; p < PHASES; p++)
        begin
            calm = (p == 3);
            case ($urandom_range(3))
                0: write_reg(REG_RADIUS, 21'd0);
                1: write_reg(REG_RADIUS, 21'd1048576);
                default: write_reg(REG_RADIUS, $urandom_range(1048576));
            endcase
            case ($urandom_range(4))
                0: ev = 32'd0;
                1: ev = 32'hFFFF_FFFF;
                2: ev = $urandom;
                default: ev = $urandom_range(1 << 26);
            endcase
            write_reg(REG_ERRLIM, ev);
            write_reg(REG_ITLIM, $urandom_range(8, 1));
            for (int i = 0; i < PER_PHASE; i++)
                send_random();
            drain();
        end
        calm = 1'b0;

        repeat (200) @(posedge clk);
        if (sb.faults == 0 && sb.awaited.size() == 0)
            $display("newton_raphson_tank_depth_solver: match");
        else
            $display("newton_raphson_tank_depth_solver: mismatch");
        $finish;
    end

endmodule

// ===== files.f =====
sv/nrtds_pkg.sv
sv/nrtds_ifc.sv
sv/nrtds_mul.sv
sv/nrtds_div.sv
sv/nrtds_dp.sv
sv/nrtds_ctrl.sv
sv/newton_raphson_tank_depth_solver.sv
sv/nrtds_chk.sv
tb/tb_newton_raphson_tank_depth_solver.sv
